// ----- src/sms_pkg.sv -----
// Package for the SPI master byte shifter: transaction payload types,
// configuration register indexes and shared constants. No dependencies.
`default_nettype none

package sms_pkg;

  localparam int TX_WIDTH          = 8;
  localparam int RX_WIDTH          = 8;
  localparam int DATA_BITS_DEFAULT = 8;
  localparam int HALF_PERIOD_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH   = 1;
  localparam int CFG_DATA_WIDTH    = HALF_PERIOD_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLOCK_PHASE = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_PERIOD = 1'd1;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [TX_WIDTH-1:0] tx_byte;
    logic                release_select;
    logic                miso_level;
  } in_item_t;

  typedef struct packed {
    logic                sclk_active;
    logic                mosi_level;
    logic                select_asserted;
    logic                busy_res;
    logic [RX_WIDTH-1:0] rx_byte;
    logic                rx_valid;
  } out_item_t;

  typedef struct packed {
    logic clock_phase;
    logic [HALF_PERIOD_WIDTH-1:0] half_period_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/sms_in_stage.sv -----
// Input register of the SPI master byte shifter.
// Depends on sms_pkg for the input transaction type.
`default_nettype none

module sms_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sms_pkg::in_item_t in_data,
  input  wire logic              step,
  output logic                   held_valid,
  output sms_pkg::in_item_t      held_data
);
  import sms_pkg::*;

  assign in_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/sms_engine.sv -----
// Shift engine of the SPI master: configuration registers, transfer state
// and the next-state logic for one transaction. Depends on sms_pkg.
`default_nettype none

module sms_engine #(
  parameter int DATA_BITS = sms_pkg::DATA_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [sms_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [sms_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  wire logic                                  step,
  input  wire sms_pkg::in_item_t                     item,
  output sms_pkg::out_item_t                         result
);
  import sms_pkg::*;

  localparam int BIT_W = $clog2(DATA_BITS);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(DATA_BITS - 1);

  cfg_t cfg;

  logic [DATA_BITS-1:0]         send_shift, send_shift_next;
  logic [DATA_BITS-1:0]         receive_shift, receive_shift_next;
  logic [BIT_W-1:0]             bit_number, bit_number_next;
  logic                         half_phase, half_phase_next;
  logic [HALF_PERIOD_WIDTH-1:0] tick_divider, tick_divider_next;
  logic                         active_flag, active_flag_next;
  logic                         select_flag, select_flag_next;
  logic                         release_pending, release_pending_next;
  logic                         clock_level, clock_level_next;
  logic                         mosi_register, mosi_register_next;

  logic [HALF_PERIOD_WIDTH-1:0] limit;
  logic [HALF_PERIOD_WIDTH-1:0] div_inc;
  logic [DATA_BITS-1:0]         rx_shifted;
  logic [DATA_BITS-1:0]         tx_shifted;
  logic                         done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_phase       <= 1'b0;
      cfg.half_period_ticks <= HALF_PERIOD_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLOCK_PHASE: cfg.clock_phase       <= cfg_data[0];
        REG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    limit      = (cfg.half_period_ticks == '0) ? HALF_PERIOD_WIDTH'(1)
                                                : cfg.half_period_ticks;
    div_inc    = tick_divider + HALF_PERIOD_WIDTH'(1);
    rx_shifted = {receive_shift[DATA_BITS-2:0], item.miso_level};
    tx_shifted = {send_shift[DATA_BITS-2:0], 1'b0};

    send_shift_next      = send_shift;
    receive_shift_next   = receive_shift;
    bit_number_next      = bit_number;
    half_phase_next      = half_phase;
    tick_divider_next    = tick_divider;
    active_flag_next     = active_flag;
    select_flag_next     = select_flag;
    release_pending_next = release_pending;
    clock_level_next     = clock_level;
    mosi_register_next   = mosi_register;
    done                 = 1'b0;

    if (item.mode == MODE_START) begin
      if (!active_flag) begin
        send_shift_next      = DATA_BITS'(item.tx_byte);
        receive_shift_next   = '0;
        bit_number_next      = '0;
        half_phase_next      = 1'b0;
        tick_divider_next    = '0;
        active_flag_next     = 1'b1;
        select_flag_next     = 1'b1;
        release_pending_next = item.release_select;
        clock_level_next     = 1'b0;
        if (!cfg.clock_phase) begin
          mosi_register_next = send_shift_next[DATA_BITS-1];
        end
      end
    end else if (active_flag) begin
      tick_divider_next = div_inc;
      if (div_inc >= limit) begin
        tick_divider_next = '0;
        if (!half_phase) begin
          clock_level_next = 1'b1;
          half_phase_next  = 1'b1;
          if (!cfg.clock_phase) begin
            receive_shift_next = rx_shifted;
          end else begin
            mosi_register_next = send_shift[DATA_BITS-1];
          end
        end else begin
          clock_level_next = 1'b0;
          half_phase_next  = 1'b0;
          send_shift_next  = tx_shifted;
          if (cfg.clock_phase) begin
            receive_shift_next = rx_shifted;
          end
          if (bit_number == LAST_BIT) begin
            bit_number_next      = '0;
            active_flag_next     = 1'b0;
            done                 = 1'b1;
            release_pending_next = 1'b0;
            if (release_pending) begin
              select_flag_next = 1'b0;
            end
          end else begin
            bit_number_next = bit_number + BIT_W'(1);
            if (!cfg.clock_phase) begin
              mosi_register_next = tx_shifted[DATA_BITS-1];
            end
          end
        end
      end
    end

    result.sclk_active     = clock_level_next;
    result.mosi_level      = mosi_register_next;
    result.select_asserted = select_flag_next;
    result.busy_res        = active_flag_next;
    result.rx_byte         = done ? RX_WIDTH'(receive_shift_next) : '0;
    result.rx_valid        = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_shift      <= '0;
      receive_shift   <= '0;
      bit_number      <= '0;
      half_phase      <= 1'b0;
      tick_divider    <= '0;
      active_flag     <= 1'b0;
      select_flag     <= 1'b0;
      release_pending <= 1'b0;
      clock_level     <= 1'b0;
      mosi_register   <= 1'b0;
    end else if (step) begin
      send_shift      <= send_shift_next;
      receive_shift   <= receive_shift_next;
      bit_number      <= bit_number_next;
      half_phase      <= half_phase_next;
      tick_divider    <= tick_divider_next;
      active_flag     <= active_flag_next;
      select_flag     <= select_flag_next;
      release_pending <= release_pending_next;
      clock_level     <= clock_level_next;
      mosi_register   <= mosi_register_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/sms_out_stage.sv -----
// Result register of the SPI master byte shifter.
// Depends on sms_pkg for the result transaction type.
`default_nettype none

module sms_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire sms_pkg::out_item_t result,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sms_pkg::out_item_t      res_data
);
  import sms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- src/spi_master_byte_shifter.sv -----
// Top level of the SPI master byte shifter: input register, shift engine
// and result register. Depends on sms_pkg, sms_in_stage, sms_engine, sms_out_stage.
//
//   Channel   Direction  Signals                         Moves
//   in        input      in_valid, in_ready, in_data     tick or start transaction
//   out       output     out_valid, out_ready, res_data  one result per transaction
//   cfg       input      cfg_we, cfg_index, cfg_data     register write
//
// A transaction accepted into the input register goes through the engine into the
// result register when that register is free, and out_valid rises then.
// One transaction is accepted every cycle while results are taken.
// Reset is synchronous and clears the transfer state and both valid flags.
// A stalled result holds the input register, and in_ready falls only then.
`default_nettype none

module spi_master_byte_shifter #(
  parameter int DATA_BITS = sms_pkg::DATA_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire sms_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output sms_pkg::out_item_t                       res_data,
  input  wire logic                                cfg_we,
  input  wire logic [sms_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [sms_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import sms_pkg::*;

  logic      held_valid;
  in_item_t  held_data;
  out_item_t result;
  logic      step;

  assign step = held_valid && (!out_valid || out_ready);

  sms_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .step       (step),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  sms_engine #(
    .DATA_BITS (DATA_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (held_data),
    .result    (result)
  );

  sms_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_data  (res_data)
  );

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("Input stalled while the result register could drain.");

  a_done_ends_transfer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_data.rx_valid) |-> !res_data.busy_res)
    else $error("Completed word reported while still busy.");

  a_rx_zero_when_not_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_data.rx_valid) |-> (res_data.rx_byte == '0))
    else $error("Received byte not zero outside completion.");

  a_busy_has_select: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_data.busy_res) |-> res_data.select_asserted)
    else $error("Transfer in progress without chip select.");

endmodule

`default_nettype wire
